// ----- rtl/sfep_pkg.sv -----
// Shared types and constants for the sensor FIFO event parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfep_pkg;

	// event codes found at the start of each event
	localparam logic [7:0] EV_TS_LOW     = 8'd252;
	localparam logic [7:0] EV_TS_LOW_WK  = 8'd246;
	localparam logic [7:0] EV_TS_HIGH    = 8'd253;
	localparam logic [7:0] EV_TS_HIGH_WK = 8'd247;
	localparam logic [7:0] EV_ACCEL      = 8'd1;
	localparam logic [7:0] EV_ACCEL_WK   = 8'd33;
	localparam logic [7:0] EV_META       = 8'd254;
	localparam logic [7:0] EV_META_WK    = 8'd248;

	// payload lengths in bytes
	localparam logic [2:0] LEN_TS    = 3'd2;
	localparam logic [2:0] LEN_ACCEL = 3'd7;
	localparam logic [2:0] LEN_META  = 3'd3;

	// bytes held before the final accel byte
	localparam int unsigned PAY_BYTES = 6;

	localparam logic KIND_ACCEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam int unsigned OUT_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [7:0]         sensor_status;
		logic [31:0]        sample_time;
		logic [7:0]         bad_code;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/sfep_parser.sv -----
// Byte-level event parser: phase, byte counter, payload bytes and timestamp.
// Depends on sfep_pkg. Produces at most one result per accepted byte.
`default_nettype none

module sfep_parser
	import sfep_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_acc,
	input  wire in_item_t  in_item,
	output logic           res_valid,
	output out_item_t      res
);

	localparam logic [2:0] PH_CODE    = 3'd0;
	localparam logic [2:0] PH_TS_LOW  = 3'd1;
	localparam logic [2:0] PH_TS_HIGH = 3'd2;
	localparam logic [2:0] PH_ACCEL   = 3'd3;
	localparam logic [2:0] PH_META    = 3'd4;
	localparam logic [2:0] PH_DISCARD = 3'd5;

	logic [2:0]                 phase_q, nxt_phase;
	logic [2:0]                 idx_q, nxt_idx, idx_inc;
	logic [31:0]                time_q, nxt_time;
	logic [PAY_BYTES-1:0][7:0]  pay_q;
	logic [2:0]                 len;
	logic                       res_hit;
	logic [7:0]                 b;

	assign b       = in_item.data_byte;
	assign idx_inc = idx_q + 3'd1;

	always_comb begin
		unique case (phase_q) inside
			PH_TS_LOW, PH_TS_HIGH: len = LEN_TS;
			PH_ACCEL:              len = LEN_ACCEL;
			PH_META:               len = LEN_META;
			default:               len = 3'd0;
		endcase
	end

	always_comb begin
		nxt_phase = phase_q;
		nxt_idx   = idx_q;
		nxt_time  = time_q;
		res_hit   = 1'b0;
		res       = '0;
		unique case (phase_q) inside
			PH_TS_LOW, PH_TS_HIGH, PH_ACCEL, PH_META: begin
				nxt_idx = idx_inc;
				if (idx_inc == len) begin
					if (phase_q == PH_TS_LOW) begin
						nxt_time = {time_q[31:16], b, pay_q[0]};
					end else if (phase_q == PH_TS_HIGH) begin
						nxt_time = {b, pay_q[0], time_q[15:0]};
					end else if (phase_q == PH_ACCEL) begin
						res_hit           = 1'b1;
						res.kind          = KIND_ACCEL;
						res.accel_z       = {pay_q[1], pay_q[0]};
						res.accel_y       = {pay_q[3], pay_q[2]};
						res.accel_x       = {pay_q[5], pay_q[4]};
						res.sensor_status = b;
						res.sample_time   = time_q;
					end
					nxt_phase = PH_CODE;
					nxt_idx   = 3'd0;
				end
			end
			PH_DISCARD: begin
			end
			default: begin
				nxt_idx = 3'd0;
				case (b) inside
					EV_TS_LOW, EV_TS_LOW_WK:   nxt_phase = PH_TS_LOW;
					EV_TS_HIGH, EV_TS_HIGH_WK: nxt_phase = PH_TS_HIGH;
					EV_ACCEL, EV_ACCEL_WK:     nxt_phase = PH_ACCEL;
					EV_META, EV_META_WK:       nxt_phase = PH_META;
					default: begin
						res_hit      = 1'b1;
						res.kind     = KIND_ERROR;
						res.bad_code = b;
						nxt_phase    = PH_DISCARD;
					end
				endcase
			end
		endcase
		if (in_item.end_of_packet) begin
			nxt_phase = PH_CODE;
			nxt_idx   = 3'd0;
		end
	end

	assign res_valid = in_acc & res_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			idx_q   <= 3'd0;
			time_q  <= '0;
		end else if (in_acc) begin
			phase_q <= nxt_phase;
			idx_q   <= nxt_idx;
			time_q  <= nxt_time;
		end
	end

	// payload bytes are always written before they are read within an event
	always_ff @(posedge clk) begin
		for (int k = 0; k < PAY_BYTES; k++) begin
			if (in_acc && idx_q == 3'(k)) begin
				pay_q[k] <= b;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sfep_out_buf.sv -----
// Two-entry result queue between the parser and the output channel.
// Depends on sfep_pkg. Lets the parser keep taking bytes while a result waits.
`default_nettype none

module sfep_out_buf
	import sfep_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_item_t push_item,
	output logic           full,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	localparam int unsigned PW = $clog2(OUT_DEPTH);
	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	out_item_t         mem [OUT_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign full      = (cnt_q == CW'(OUT_DEPTH));
	assign pop       = out_valid & ~out_stall;
	assign out_item  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(OUT_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(OUT_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sensor_fifo_event_parser_top.sv -----
// Top level of the sensor FIFO event parser: parser plus output queue.
// Depends on sfep_pkg, sfep_parser and sfep_out_buf.
`default_nettype none

// Deframes the sensor hub FIFO byte stream into accelerometer samples. One
// byte is taken per cycle whenever in_stall is low; in_stall rises only when
// the two-entry output queue is full, so with the output side draining the
// block sustains one byte every cycle. Timestamp events update the kept
// 32-bit time, meta events are skipped, each complete accelerometer event
// yields one sample (kind 0) on the byte that ends it, and an unknown code
// yields one error item (kind 1, bad_code set) on that byte, after which the
// rest of the packet is ignored. end_of_packet returns the parser to
// expecting an event code and drops any unfinished event. Each result is
// registered in the output queue and leaves it behind any earlier results.
module sensor_fifo_event_parser_top
	import sfep_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	logic      in_acc;
	logic      res_valid;
	out_item_t res;

	assign in_acc = in_valid & ~in_stall;

	sfep_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res       (res)
	);

	sfep_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_res_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_acc)
		else $error("result produced without an accepted byte");

	a_res_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid)
		else $error("queued result not visible on output");

	a_stall_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with nothing pending on output");

	a_error_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_ERROR) |->
		(res.sample_time == '0 && res.sensor_status == '0 && res.accel_x == '0))
		else $error("error item carries sample fields");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for sensor_fifo_event_parser_top: directed table, then random packets.
// Depends on sfep_pkg and the RTL of the parser top level; reads nothing else.
`timescale 1ns / 100ps

module tb_top;
	import sfep_pkg::*;

	typedef enum logic [2:0] {P_CODE, P_TS_LO, P_TS_HI, P_ACCEL, P_META, P_DROP} phase_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       eop;
		bit         typed;
		out_item_t  want;
	} dir_row_t;

	localparam out_item_t NO_RES = '0;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	// parser shadow state
	phase_t      ph_now = P_CODE;
	logic [2:0]  pay_cnt = '0;
	logic [55:0] pay_buf = '0;
	logic [31:0] stamp = '0;

	out_item_t samples_due[$];
	int        mismatches = 0;
	int        bytes_sent = 0;
	int        packets_sent = 0;
	int        samples_seen = 0;
	int        aborts_seen = 0;

	// receiver side
	logic hold_req = 1'b0;
	logic calm = 1'b0;
	bit   hold_done = 1'b0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   rx_pct = 10;
	int   rx_tick = 0;

	// extremes right after reset, every event type, packet-end and unknown-code cases
	dir_row_t dir_tab [24] = '{
		'{EV_ACCEL_WK, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'h7F, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, out_item_t'{KIND_ACCEL, 16'hFFFF, 16'h7FFF, 16'h8000,
			8'hFF, 32'h0, 8'h00}},
		'{EV_TS_LOW_WK, 1'b0, 1'b0, NO_RES},
		'{8'h34, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b0, NO_RES},
		'{EV_TS_HIGH, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{EV_META_WK, 1'b0, 1'b0, NO_RES},
		'{8'hAA, 1'b0, 1'b0, NO_RES},
		'{8'hBB, 1'b0, 1'b0, NO_RES},
		'{8'hCC, 1'b1, 1'b0, NO_RES},
		'{EV_META, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, out_item_t'{KIND_ERROR, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 8'h00}},
		'{EV_ACCEL, 1'b1, 1'b0, NO_RES},
		'{EV_ACCEL, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, out_item_t'{KIND_ERROR, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 8'hFF}}
	};

	sensor_fifo_event_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void restart(input phase_t p);
		ph_now = p;
		pay_cnt = '0;
		pay_buf = '0;
	endfunction

	// Advance the shadow parser by one byte; returns 1 when the byte yields an item.
	function automatic bit decode_byte(input in_item_t it, output out_item_t res);
		logic [2:0] need;
		logic [7:0] b;
		bit got;
		b = it.data_byte;
		got = 1'b0;
		res = '0;
		case (ph_now)
			P_TS_LO, P_TS_HI, P_ACCEL, P_META: begin
				pay_buf = pay_buf | (56'(b) << (8 * pay_cnt));
				pay_cnt = pay_cnt + 3'd1;
				need = (ph_now == P_ACCEL) ? LEN_ACCEL : (ph_now == P_META) ? LEN_META : LEN_TS;
				if (pay_cnt >= need) begin
					if (ph_now == P_TS_LO) begin
						stamp[15:0] = pay_buf[15:0];
					end else if (ph_now == P_TS_HI) begin
						stamp[31:16] = pay_buf[15:0];
					end else if (ph_now == P_ACCEL) begin
						res.kind = KIND_ACCEL;
						res.accel_z = pay_buf[15:0];
						res.accel_y = pay_buf[31:16];
						res.accel_x = pay_buf[47:32];
						res.sensor_status = pay_buf[55:48];
						res.sample_time = stamp;
						got = 1'b1;
					end
					restart(P_CODE);
				end
			end
			P_DROP: begin
			end
			default: begin
				if (b == EV_TS_LOW || b == EV_TS_LOW_WK) begin
					restart(P_TS_LO);
				end else if (b == EV_TS_HIGH || b == EV_TS_HIGH_WK) begin
					restart(P_TS_HI);
				end else if (b == EV_ACCEL || b == EV_ACCEL_WK) begin
					restart(P_ACCEL);
				end else if (b == EV_META || b == EV_META_WK) begin
					restart(P_META);
				end else begin
					res.kind = KIND_ERROR;
					res.bad_code = b;
					got = 1'b1;
					restart(P_DROP);
				end
			end
		endcase
		if (it.end_of_packet)
			restart(P_CODE);
		return got;
	endfunction

	task automatic flag(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic take_result(input out_item_t seen);
		out_item_t want;
		if (samples_due.size() == 0) begin
			flag($sformatf("unexpected output item, kind %0d", seen.kind));
		end else begin
			want = samples_due.pop_front();
			if (want.kind == KIND_ACCEL)
				samples_seen++;
			else
				aborts_seen++;
			if (seen.kind !== want.kind)
				flag($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
			if (seen.accel_x !== want.accel_x)
				flag($sformatf("accel_x %0d, expected %0d", seen.accel_x, want.accel_x));
			if (seen.accel_y !== want.accel_y)
				flag($sformatf("accel_y %0d, expected %0d", seen.accel_y, want.accel_y));
			if (seen.accel_z !== want.accel_z)
				flag($sformatf("accel_z %0d, expected %0d", seen.accel_z, want.accel_z));
			if (seen.sensor_status !== want.sensor_status)
				flag($sformatf("sensor_status %h, expected %h",
					seen.sensor_status, want.sensor_status));
			if (seen.sample_time !== want.sample_time)
				flag($sformatf("sample_time %h, expected %h", seen.sample_time, want.sample_time));
			if (seen.bad_code !== want.bad_code)
				flag($sformatf("bad_code %h, expected %h", seen.bad_code, want.bad_code));
		end
	endtask

	// output monitor and stall generator
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			take_result(out_item);
		rx_tick++;
		if (rx_tick % 200 == 0)
			rx_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 8 : 25);
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			// long hold-off so the output queue fills and the parser stalls its input
			hold_done = 1'b1;
			hold_left = 149;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_pct) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] rand_data();
		if ($urandom_range(0, 4) == 0)
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'h80;
				default: return 8'h7F;
			endcase
		return 8'($urandom);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eop, input int idle_pct,
		output bit got, output out_item_t res);
		in_item_t it;
		it.data_byte = b;
		it.end_of_packet = eop;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		bytes_sent++;
		got = decode_byte(it, res);
	endtask

	// Mostly well-formed events with random payloads; some unknown codes, noise and cut packets.
	task automatic random_packet(input int idle_pct);
		logic [7:0] pkt[$];
		logic [7:0] code;
		bit known;
		bit got;
		out_item_t res;
		int n_ev;
		int r;
		int cut;
		n_ev = $urandom_range(1, 5);
		for (int e = 0; e < n_ev; e++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				pkt.push_back(r[0] ? EV_ACCEL : EV_ACCEL_WK);
				repeat (LEN_ACCEL) pkt.push_back(rand_data());
			end else if (r < 55) begin
				pkt.push_back(r[0] ? EV_TS_LOW : EV_TS_LOW_WK);
				repeat (LEN_TS) pkt.push_back(rand_data());
			end else if (r < 68) begin
				pkt.push_back(r[0] ? EV_TS_HIGH : EV_TS_HIGH_WK);
				repeat (LEN_TS) pkt.push_back(rand_data());
			end else if (r < 80) begin
				pkt.push_back(r[0] ? EV_META : EV_META_WK);
				repeat (LEN_META) pkt.push_back(rand_data());
			end else if (r < 88) begin
				do begin
					code = 8'($urandom);
					known = code == EV_TS_LOW || code == EV_TS_LOW_WK || code == EV_TS_HIGH
						|| code == EV_TS_HIGH_WK || code == EV_ACCEL || code == EV_ACCEL_WK
						|| code == EV_META || code == EV_META_WK;
				end while (known);
				pkt.push_back(code);
				repeat ($urandom_range(0, 3)) pkt.push_back(rand_data());
			end else begin
				repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, pkt.size());
			while (pkt.size() > cut)
				void'(pkt.pop_back());
		end
		foreach (pkt[k]) begin
			send_byte(pkt[k], k == pkt.size() - 1, idle_pct, got, res);
			if (got)
				samples_due.push_back(res);
		end
		packets_sent++;
	endtask

	initial begin
		bit got;
		out_item_t res;
		int idle_pct;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].data_byte, dir_tab[i].eop, 20, got, res);
			if (dir_tab[i].typed)
				samples_due.push_back(dir_tab[i].want);
			else if (got)
				samples_due.push_back(res);
		end
		while (bytes_sent < 700) begin
			if (packets_sent == 5)
				hold_req <= 1'b1;
			if (packets_sent == 15) begin
				// sender goes quiet until the block has drained
				in_valid <= 1'b0;
				do @(posedge clk); while (samples_due.size() != 0);
			end
			if (bytes_sent >= 600)
				calm <= 1'b1;
			if (bytes_sent >= 600 || (packets_sent >= 5 && packets_sent < 12))
				idle_pct = 0;
			else
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			random_packet(idle_pct);
		end
		in_valid <= 1'b0;
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes (%0d random packets plus directed rows).",
			bytes_sent, packets_sent);
		$display("Checked %0d accel samples and %0d unknown-code items.",
			samples_seen, aborts_seen);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sfep_pkg.sv
rtl/sfep_parser.sv
rtl/sfep_out_buf.sv
rtl/sensor_fifo_event_parser_top.sv
bench/tb_top.sv
